[hw/rtl/vrm_pkg.sv]
// Package with shared constants, types and helpers of the voxel ray marcher.
package vrm_pkg;

  localparam int VOXEL_SLOTS = 16;
  localparam int COORD_BITS  = 16;
  localparam int SLOT_IDX_W  = (VOXEL_SLOTS > 1) ? $clog2(VOXEL_SLOTS) : 1;

  localparam int FIELD_W    = 16;
  localparam int SLOT_W     = 4;
  localparam int CHAN_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int LIMIT_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [COUNT_W-1:0] ACTIVE_COUNT_RST = '0;
  localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST   = 8'd51;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CAST = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_COUNT = 1'b0,
    CFG_STEP_LIMIT   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } colour_t;

  // Lowest matching slot among the searched ones, with its colour.
  typedef struct packed {
    logic      hit;
    slot_idx_t slot;
    colour_t   colour;
  } match_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    colour_t           colour;
  } result_t;

  // Finished cast handed from the marcher to the output register.
  typedef struct packed {
    logic    valid;
    result_t res;
  } march_out_t;

  // Sign-extends (or truncates) a 16-bit input field to the coordinate width.
  function automatic coord_t to_coord(input logic signed [FIELD_W-1:0] v);
    return COORD_BITS'(v);
  endfunction

endpackage

[hw/rtl/vrm_if.sv]
// Channel interfaces of the voxel ray marcher: input items, results, configuration.
interface vrm_in_if;
  import vrm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [SLOT_W-1:0]          slot;
  logic signed [FIELD_W-1:0]  pos_x;
  logic signed [FIELD_W-1:0]  pos_y;
  logic signed [FIELD_W-1:0]  pos_z;
  logic signed [FIELD_W-1:0]  step_x;
  logic signed [FIELD_W-1:0]  step_y;
  logic signed [FIELD_W-1:0]  step_z;
  logic [CHAN_W-1:0]          red_in;
  logic [CHAN_W-1:0]          green_in;
  logic [CHAN_W-1:0]          blue_in;

  modport source (
    output valid, opcode, slot, pos_x, pos_y, pos_z, step_x, step_y, step_z,
           red_in, green_in, blue_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot, pos_x, pos_y, pos_z, step_x, step_y, step_z,
           red_in, green_in, blue_in,
    output ready
  );
endinterface

interface vrm_out_if;
  import vrm_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;

  modport source (
    output valid, hit, hit_slot, red_out, green_out, blue_out,
    input  ready
  );
  modport sink (
    input  valid, hit, hit_slot, red_out, green_out, blue_out,
    output ready
  );
endinterface

interface vrm_cfg_if;
  import vrm_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/vrm_voxel_table.sv]
// Voxel slot registers with a parallel position compare and lowest-slot select.
module vrm_voxel_table (
  input  logic                          clk,
  input  logic                          wr_en,
  input  vrm_pkg::slot_idx_t            wr_slot,
  input  vrm_pkg::point_t               wr_point,
  input  vrm_pkg::colour_t              wr_colour,
  input  vrm_pkg::point_t               probe,
  input  logic [vrm_pkg::COUNT_W-1:0]   active_count,
  output vrm_pkg::match_t               match
);
  import vrm_pkg::*;

  point_t                 coord_r  [VOXEL_SLOTS];
  colour_t                colour_r [VOXEL_SLOTS];
  logic [VOXEL_SLOTS-1:0] eq;
  slot_idx_t              first_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coord_r[wr_slot]  <= wr_point;
      colour_r[wr_slot] <= wr_colour;
    end
  end

  // Every slot below the active count compares against the probe point.
  for (genvar i = 0; i < VOXEL_SLOTS; i++) begin : g_cmp
    assign eq[i] = (i < int'(active_count)) && (coord_r[i] == probe);
  end

  always_comb begin
    first_idx = '0;
    for (int i = VOXEL_SLOTS - 1; i >= 0; i--) begin
      if (eq[i]) begin
        first_idx = SLOT_IDX_W'(i);
      end
    end
  end

  assign match.hit    = |eq;
  assign match.slot   = first_idx;
  assign match.colour = colour_r[first_idx];

endmodule

[hw/rtl/vrm_marcher.sv]
// Sequencer that steps the ray point with one shared adder and detects the end of a cast.
module vrm_marcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  vrm_pkg::point_t               start_point,
  input  vrm_pkg::point_t               step,
  input  logic [vrm_pkg::LIMIT_W-1:0]   step_limit,
  input  vrm_pkg::match_t               match,
  input  logic                          fin_ack,
  output vrm_pkg::point_t               probe,
  output logic                          busy,
  output vrm_pkg::march_out_t           fin
);
  import vrm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARCH,
    ST_EMPTY
  } state_t;

  state_t             state_r;
  point_t             point_r;
  point_t             step_r;
  logic [LIMIT_W-1:0] cnt_r;

  point_t add_a;
  point_t add_b;
  point_t sum;
  logic   march_hit;
  logic   done;

  // The one adder: start point plus step on entry, then point plus step.
  assign add_a = (state_r == ST_IDLE) ? start_point : point_r;
  assign add_b = (state_r == ST_IDLE) ? step : step_r;
  assign sum.x = add_a.x + add_b.x;
  assign sum.y = add_a.y + add_b.y;
  assign sum.z = add_a.z + add_b.z;

  assign probe     = point_r;
  assign busy      = (state_r != ST_IDLE);
  assign march_hit = (state_r == ST_MARCH) && match.hit;
  assign done      = ((state_r == ST_MARCH) && (match.hit || (cnt_r == step_limit))) ||
                     (state_r == ST_EMPTY);

  assign fin.valid          = done;
  assign fin.res.hit        = march_hit;
  assign fin.res.slot       = march_hit ? SLOT_W'(match.slot) : '0;
  assign fin.res.colour     = march_hit ? match.colour : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            point_r <= sum;
            step_r  <= step;
            cnt_r   <= LIMIT_W'(1);
            state_r <= (step_limit == '0) ? ST_EMPTY : ST_MARCH;
          end
        end
        ST_MARCH: begin
          if (done) begin
            if (fin_ack) begin
              state_r <= ST_IDLE;
            end
          end else begin
            point_r <= sum;
            cnt_r   <= cnt_r + LIMIT_W'(1);
          end
        end
        ST_EMPTY: begin
          if (fin_ack) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/voxel_ray_marcher.sv]
// Top level of the voxel ray marcher: configuration, channel handshakes and result register.
//
//   Channel   Direction  Handshake          Carries
//   in_ch     sink       valid / ready      opcode, slot, start or voxel position, step, colour
//   out_ch    source     valid / ready      hit, hit_slot, red, green, blue (one per cast)
//   cfg_ch    sink       valid / ready      register index, write data
//
// A load item writes its slot at the edge at which it is taken; it gives no result.
// A cast item forms its first point on entry; then each march step compares the point
// against all active slots at once while the shared adder forms the next point, until a
// hit or the step limit ends the cast and its result is registered.
// A zero step limit still passes through the entry and an empty state that registers a miss.
// in_ch.ready is low while a cast is in flight; a result that cannot leave because the
// output register is still full holds the marcher in place until out_ch.ready frees it.
// Reset (rst_n low at a clock edge) sets active_count to 0 and step_limit to 51 and
// empties the marcher and the output register; the voxel slots keep whatever they held.
module voxel_ray_marcher (
  input logic       clk,
  input logic       rst_n,
  vrm_in_if.sink    in_ch,
  vrm_out_if.source out_ch,
  vrm_cfg_if.sink   cfg_ch
);
  import vrm_pkg::*;

  logic [COUNT_W-1:0] active_count_r;
  logic [LIMIT_W-1:0] step_limit_r;

  logic       in_accept;
  logic       load_en;
  logic       start;
  logic       busy;
  logic       out_free;
  logic       out_valid_r;
  result_t    out_res_r;

  point_t     in_point;
  point_t     in_step;
  colour_t    in_colour;
  point_t     probe;
  match_t     match;
  march_out_t fin;

  // Config writes taken at once, unchecked; user must send them only while the block is idle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r <= ACTIVE_COUNT_RST;
      step_limit_r   <= STEP_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_ACTIVE_COUNT: active_count_r <= cfg_ch.data[COUNT_W-1:0];
        CFG_STEP_LIMIT:   step_limit_r   <= cfg_ch.data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input side: loads go straight to the table, casts start the marcher.
  assign in_ch.ready = !busy;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign load_en     = in_accept && (in_ch.opcode == OP_LOAD) &&
                       (int'(in_ch.slot) < VOXEL_SLOTS);
  assign start       = in_accept && (in_ch.opcode == OP_CAST);

  assign in_point.x       = to_coord(in_ch.pos_x);
  assign in_point.y       = to_coord(in_ch.pos_y);
  assign in_point.z       = to_coord(in_ch.pos_z);
  assign in_step.x        = to_coord(in_ch.step_x);
  assign in_step.y        = to_coord(in_ch.step_y);
  assign in_step.z        = to_coord(in_ch.step_z);
  assign in_colour.red    = in_ch.red_in;
  assign in_colour.green  = in_ch.green_in;
  assign in_colour.blue   = in_ch.blue_in;

  vrm_voxel_table u_table (
    .clk          (clk),
    .wr_en        (load_en),
    .wr_slot      (SLOT_IDX_W'(in_ch.slot)),
    .wr_point     (in_point),
    .wr_colour    (in_colour),
    .probe        (probe),
    .active_count (active_count_r),
    .match        (match)
  );

  vrm_marcher u_marcher (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .start_point (in_point),
    .step        (in_step),
    .step_limit  (step_limit_r),
    .match       (match),
    .fin_ack     (out_free),
    .probe       (probe),
    .busy        (busy),
    .fin         (fin)
  );

  // Output register: it can take a new result when empty or when its item leaves.
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (fin.valid && out_free) begin
        out_valid_r <= 1'b1;
        out_res_r   <= fin.res;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_res_r.hit;
  assign out_ch.hit_slot  = out_res_r.slot;
  assign out_ch.red_out   = out_res_r.colour.red;
  assign out_ch.green_out = out_res_r.colour.green;
  assign out_ch.blue_out  = out_res_r.colour.blue;

  // A cast taken keeps the input closed in the next cycle.
  a_cast_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_ch.opcode == OP_CAST)) |=> !in_ch.ready)
    else $error("input ready while a cast is in flight");

  // A new result only ever comes out of a cast that was in flight.
  a_result_from_cast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !$past(out_ch.valid)) |-> $past(busy))
    else $error("result appeared without a cast in flight");

  // A load never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_ch.opcode == OP_LOAD) && !out_ch.valid) |=> !out_ch.valid)
    else $error("result appeared after a load");

endmodule

[tb/vrm_checker.sv]
// Checker that follows loads and register writes, predicts each cast's result and compares it.
`timescale 1ns / 1ps
module vrm_checker (
  input  logic clk,
  input  logic rst_n,
  vrm_in_if    in_ch,
  vrm_out_if   out_ch,
  vrm_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import vrm_pkg::*;

  point_t             voxel_pos [VOXEL_SLOTS];
  colour_t            voxel_col [VOXEL_SLOTS];
  logic [COUNT_W-1:0] search_count = ACTIVE_COUNT_RST;
  logic [LIMIT_W-1:0] march_limit  = STEP_LIMIT_RST;
  result_t            expected_hits [$];

  // Walks the ray and returns the lowest searched slot met at the first matching position.
  function automatic result_t march_ray(point_t start, point_t dir);
    point_t  p;
    result_t r;
    int      n;
    r = '0;
    p = start;
    n = (int'(search_count) > VOXEL_SLOTS) ? VOXEL_SLOTS : int'(search_count);
    for (int k = 0; k < int'(march_limit) && !r.hit; k++) begin
      p.x = p.x + dir.x;
      p.y = p.y + dir.y;
      p.z = p.z + dir.z;
      // Scanning downward leaves the lowest matching slot in r.
      for (int i = n - 1; i >= 0; i--) begin
        if (voxel_pos[i] == p) begin
          r.hit    = 1'b1;
          r.slot   = SLOT_W'(i);
          r.colour = voxel_col[i];
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    point_t  start;
    point_t  dir;
    result_t want;
    if (!rst_n) begin
      search_count = ACTIVE_COUNT_RST;
      march_limit  = STEP_LIMIT_RST;
      expected_hits.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          $error("result with no cast waiting: hit %0d, slot %0d", out_ch.hit, out_ch.hit_slot);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          check_field("hit", want.hit, out_ch.hit);
          check_field("hit_slot", want.slot, out_ch.hit_slot);
          check_field("red_out", want.colour.red, out_ch.red_out);
          check_field("green_out", want.colour.green, out_ch.green_out);
          check_field("blue_out", want.colour.blue, out_ch.blue_out);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_ACTIVE_COUNT: search_count = COUNT_W'(cfg_ch.data);
          CFG_STEP_LIMIT:   march_limit  = LIMIT_W'(cfg_ch.data);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        start.x = COORD_BITS'(in_ch.pos_x);
        start.y = COORD_BITS'(in_ch.pos_y);
        start.z = COORD_BITS'(in_ch.pos_z);
        if (in_ch.opcode == OP_LOAD) begin
          if (int'(in_ch.slot) < VOXEL_SLOTS) begin
            voxel_pos[in_ch.slot] = start;
            voxel_col[in_ch.slot] = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
          end
        end else begin
          dir.x = COORD_BITS'(in_ch.step_x);
          dir.y = COORD_BITS'(in_ch.step_y);
          dir.z = COORD_BITS'(in_ch.step_z);
          expected_hits.push_back(march_ray(start, dir));
        end
      end
    end
    pending = expected_hits.size();
  end

endmodule

[tb/testbench.sv]
// Top of the voxel ray marcher testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import vrm_pkg::*;

  // A cast is bounded by the step limit and the receiver's stall; about 1800 items of the slowest
  // kind stay far below this limit, which only catches a hung block.
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 195;
  // A cast with a zero step limit still passes through the entry and an empty state, so the
  // block is left to settle after its last result before a register is touched.
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    opcode_t                   op;
    logic [SLOT_W-1:0]         slot;
    logic signed [FIELD_W-1:0] px;
    logic signed [FIELD_W-1:0] py;
    logic signed [FIELD_W-1:0] pz;
    logic signed [FIELD_W-1:0] sx;
    logic signed [FIELD_W-1:0] sy;
    logic signed [FIELD_W-1:0] sz;
    logic [CHAN_W-1:0]         r;
    logic [CHAN_W-1:0]         g;
    logic [CHAN_W-1:0]         b;
  } ray_item_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   src_idle_pct;
  int   sink_idle_pct;

  // What the stimulus knows of the table, used only to aim casts at loaded voxels.
  int   shadow_x [VOXEL_SLOTS];
  int   shadow_y [VOXEL_SLOTS];
  int   shadow_z [VOXEL_SLOTS];
  int   live_slots;
  int   cur_limit;

  vrm_in_if  in_ch ();
  vrm_out_if out_ch ();
  vrm_cfg_if cfg_ch ();

  voxel_ray_marcher uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  vrm_checker ray_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver decides anew at every falling edge whether it takes a result.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // A value spread evenly over -span .. span.
  function automatic int small_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // A load fills the step fields with noise, since the block must ignore them.
  function automatic ray_item_t load_item(int slot, int x, int y, int z, logic [23:0] rgb);
    ray_item_t it;
    it.op   = OP_LOAD;
    it.slot = SLOT_W'(slot);
    it.px   = FIELD_W'(x);
    it.py   = FIELD_W'(y);
    it.pz   = FIELD_W'(z);
    it.sx   = FIELD_W'($urandom);
    it.sy   = FIELD_W'($urandom);
    it.sz   = FIELD_W'($urandom);
    {it.r, it.g, it.b} = rgb;
    return it;
  endfunction

  // A cast likewise carries noise in the slot and colour fields.
  function automatic ray_item_t cast_item(int x, int y, int z, int dx, int dy, int dz);
    ray_item_t it;
    it.op   = OP_CAST;
    it.slot = SLOT_W'($urandom);
    it.px   = FIELD_W'(x);
    it.py   = FIELD_W'(y);
    it.pz   = FIELD_W'(z);
    it.sx   = FIELD_W'(dx);
    it.sy   = FIELD_W'(dy);
    it.sz   = FIELD_W'(dz);
    {it.r, it.g, it.b} = 24'($urandom);
    return it;
  endfunction

  // Most casts are aimed: they start k steps short of a loaded voxel, with k inside the
  // current step limit, so they reach deep into the march. The rest are loads, casts through
  // the crowded region near the origin, and casts with fully random fields.
  function automatic ray_item_t random_item();
    int pick;
    int s;
    int k;
    int dx;
    int dy;
    int dz;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if ($urandom_range(0, 9) < 7) begin
        return load_item($urandom_range(0, VOXEL_SLOTS - 1), small_coord(8), small_coord(8),
                         small_coord(8), 24'($urandom));
      end
      return load_item($urandom_range(0, VOXEL_SLOTS - 1), small_coord(32768),
                       small_coord(32768), small_coord(32768), 24'($urandom));
    end
    if (pick < 75 && live_slots > 0) begin
      s = $urandom_range(0, live_slots - 1);
      k = $urandom_range(1, (cur_limit > 0) ? cur_limit : 1);
      if ($urandom_range(0, 3) == 0) begin
        dx = small_coord(32768);
        dy = small_coord(32768);
        dz = small_coord(32768);
      end else begin
        dx = small_coord(3);
        dy = small_coord(3);
        dz = small_coord(3);
      end
      return cast_item(shadow_x[s] - k * dx, shadow_y[s] - k * dy, shadow_z[s] - k * dz,
                       dx, dy, dz);
    end
    if (pick < 88) begin
      return cast_item(small_coord(10), small_coord(10), small_coord(10),
                       small_coord(2), small_coord(2), small_coord(2));
    end
    return cast_item(small_coord(32768), small_coord(32768), small_coord(32768),
                     small_coord(32768), small_coord(32768), small_coord(32768));
  endfunction

  // Called at a falling edge; returns at the falling edge after the item was taken.
  // Valid is only lowered inside an idle gap, so it never drops and rises in one step.
  task automatic send_item(ray_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    if (it.op == OP_LOAD && int'(it.slot) < VOXEL_SLOTS) begin
      shadow_x[it.slot] = it.px;
      shadow_y[it.slot] = it.py;
      shadow_z[it.slot] = it.pz;
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= it.op;
    in_ch.slot     <= it.slot;
    in_ch.pos_x    <= it.px;
    in_ch.pos_y    <= it.py;
    in_ch.pos_z    <= it.pz;
    in_ch.step_x   <= it.sx;
    in_ch.step_y   <= it.sy;
    in_ch.step_z   <= it.sz;
    in_ch.red_in   <= it.r;
    in_ch.green_in <= it.g;
    in_ch.blue_in  <= it.b;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every cast has delivered its result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both registers with raw 8-bit data while the block is idle.
  task automatic configure(logic [7:0] count_raw, logic [7:0] limit_raw);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ACTIVE_COUNT;
    cfg_ch.data  <= count_raw;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.index <= CFG_STEP_LIMIT;
    cfg_ch.data  <= limit_raw;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    // Only the low five bits of the count are kept, and counts above the table size
    // search the whole table.
    live_slots = (int'(count_raw[4:0]) > VOXEL_SLOTS) ? VOXEL_SLOTS : int'(count_raw[4:0]);
    cur_limit  = limit_raw;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_LOAD;
    in_ch.slot     = '0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.pos_z    = '0;
    in_ch.step_x   = '0;
    in_ch.step_y   = '0;
    in_ch.step_z   = '0;
    in_ch.red_in   = '0;
    in_ch.green_in = '0;
    in_ch.blue_in  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_ACTIVE_COUNT;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    src_idle_pct   = 12;
    sink_idle_pct  = 71;
    live_slots     = 0;
    cur_limit      = 51;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Right after reset nothing is searched, so this cast must miss.
    send_item(cast_item(0, 0, 0, 1, 1, 1));

    // Fill the whole table before any slot is searched. Slot 5 shares the position of
    // slot 3 to show that the lower slot wins; slots 0, 14 and 15 sit at the corners
    // of the coordinate range.
    for (int i = 0; i < VOXEL_SLOTS; i++) begin
      case (i)
        0:       send_item(load_item(0, -32768, 32767, -32768, 24'hFF00FF));
        5:       send_item(load_item(5, 3, 6, -3, 24'($urandom)));
        14:      send_item(load_item(14, 32767, 32767, 32767, 24'h000000));
        15:      send_item(load_item(15, -32768, -32768, -32768, 24'hFFFFFF));
        default: send_item(load_item(i, i, 2 * i, -i, 24'($urandom)));
      endcase
    end
    configure(8'h10, 8'd51);

    send_item(cast_item(0, 0, 0, 1, 2, -1));
    send_item(cast_item(0, 0, 0, 3, 6, -3));
    // The sum wraps from the most negative corner to the most positive one.
    send_item(cast_item(-32768, -32768, -32768, -1, -1, -1));
    send_item(cast_item(0, 0, 0, -32768, -32768, -32768));
    send_item(cast_item(0, 0, 0, -32768, 32767, -32768));
    // A zero step tests the start point over and over.
    send_item(cast_item(1, 2, -1, 0, 0, 0));
    send_item(cast_item(1000, 1000, 1000, 0, 0, 0));
    // The voxel is reached on exactly the last permitted step, then one step too late.
    send_item(cast_item(1, 2, -52, 0, 0, 1));
    send_item(cast_item(1, 2, -53, 0, 0, 1));
    // With a zero step limit no position is tested at all.
    configure(8'h10, 8'd0);
    send_item(cast_item(0, 0, 0, 1, 2, -1));

    for (int ph = 0; ph < PHASES; ph++) begin
      // Three phases each: slow receiver, then slow sender, then full speed on both sides.
      case (ph / 3)
        0: begin
          src_idle_pct  = 12;
          sink_idle_pct = 71;
        end
        1: begin
          src_idle_pct  = 71;
          sink_idle_pct = 12;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      case (ph)
        0:       configure(8'h10, 8'd51);
        1:       configure(8'hFF, 8'd255);
        2:       configure(8'h01, 8'd1);
        3:       configure(8'h08, 8'd20);
        4:       configure(8'hE0, 8'd40);
        5:       configure(8'($urandom), 8'($urandom_range(1, 64)));
        6:       configure(8'h13, 8'd100);
        7:       configure(8'h0F, 8'd37);
        default: configure(8'($urandom), 8'($urandom_range(0, 80)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through some phases the sender holds back until the block has emptied.
        if (n == PHASE_ITEMS / 2 && ph % 3 == 1) begin
          drain();
        end
        send_item(random_item());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
